[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the CRC-32 block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define CRCH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");
// When the condition holds, the consequence must hold in the next cycle.
`define CRCH_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed: label");
`else
`define CRCH_ASSERT(label, clk, rst, prop)
`define CRCH_ASSERT_NEXT(label, clk, rst, cond, cons)
`endif

`endif

[rtl/core/crc32h_pkg.sv]
// Shared constants, types and the byte-wise CRC-32 fold for the CRC-32 block.
package crc32h_pkg;

   localparam int unsigned DefaultMaxPacketBytes = 65536;

   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [16:0] HOLE_BYTES   = 17'd4;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLE_ENABLE     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHECKSUM_OFFSET = 2'd1;

   typedef struct packed {
      logic        enable;
      logic [15:0] offset;
   } hole_cfg_type;

   // Folds one byte into the reflected CRC, least significant bit first.
   // The eight steps flatten into a shallow XOR network.
   function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] v;
      v = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      return v;
   endfunction

endpackage

[rtl/core/crc32h_update.sv]
// Next-state logic for one byte: hole masking, CRC fold and position count.
module crc32h_update #(
   parameter logic [15:0] PosLimit = 16'hFFFF
) (
   input  logic [31:0]               crc_cur,
   input  logic [15:0]               pos_cur,
   input  logic [7:0]                data_byte,
   input  logic                      first_byte,
   input  crc32h_pkg::hole_cfg_type  hole_cfg,
   output logic [31:0]               crc_next,
   output logic [15:0]               pos_next
);
   import crc32h_pkg::*;

   logic [31:0] crc_base;
   logic [15:0] pos_base;
   logic [16:0] hole_end;
   logic        in_hole;
   logic [7:0]  fed_byte;

   // A first byte restarts both the CRC and the position.
   assign crc_base = first_byte ? CRC_ALL_ONES : crc_cur;
   assign pos_base = first_byte ? 16'd0 : pos_cur;

   // The hole end is one bit wider so it never wraps.
   assign hole_end = {1'b0, hole_cfg.offset} + HOLE_BYTES;
   assign in_hole  = hole_cfg.enable && (pos_base >= hole_cfg.offset)
                     && ({1'b0, pos_base} < hole_end);
   assign fed_byte = in_hole ? 8'd0 : data_byte;

   assign crc_next = fold_byte(crc_base, fed_byte);
   assign pos_next = (pos_base < PosLimit) ? (pos_base + 16'd1) : pos_base;

endmodule

[rtl/core/crc32_with_checksum_hole.sv]
// Top level of the CRC-32 block with a zeroed four-byte checksum hole.
//
// Usage: packet bytes arrive on the req_ channel, one word per handshake,
// with first and last markers. A word is taken at a clock edge where
// req_valid is high and req_stall is low. The word carrying the last marker
// produces one finished, inverted CRC-32 on the rsp_ channel; other words
// produce nothing. The csr_ channel sets the hole enable and the checksum
// offset; it is always ready and should only be written while idle.
// Timing: a taken word waits in the input register and is folded into the
// running CRC as it leaves that register; for a last word the result register
// is loaded at that edge and shown on rsp_valid. Throughput is one word per
// cycle while req_stall is low, set by the single byte-wide XOR network
// between the input register and the running CRC register.
// Reset clears the channel valids, the configuration, the running CRC to all
// ones and the byte position to zero. When the receiver stalls, the result
// register holds its word; the block keeps taking and folding non-final
// bytes and only raises req_stall when a last word waits behind a held result.
module crc32_with_checksum_hole #(
   parameter int unsigned MAX_PACKET_BYTES = crc32h_pkg::DefaultMaxPacketBytes
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Input channel.
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [7:0]                             req_data_byte,
   input  logic                                   req_first_byte,
   input  logic                                   req_last_byte,
   // Result channel.
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [31:0]                            rsp_crc_result,
   // Configuration write channel.
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [crc32h_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [crc32h_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import crc32h_pkg::*;

`include "assert_macros.svh"

   // The position is 16 bits wide and saturates at min(MAX-1, 65535).
   localparam logic [15:0] PosLimit =
      ((MAX_PACKET_BYTES - 1) > 65535) ? 16'hFFFF : 16'(MAX_PACKET_BYTES - 1);

   // Configuration registers.
   hole_cfg_type hole_cfg_ff, hole_cfg_in;

   // Input register stage.
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_data_ff;
   logic        s1_first_ff;
   logic        s1_last_ff;

   // Running state.
   logic [31:0] crc_running_ff, crc_running_in;
   logic [15:0] byte_position_ff, byte_position_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_crc_ff;

   logic        req_fire;
   logic        out_free;
   logic        s1_advance;
   logic        s1_fire;
   logic [31:0] crc_next;
   logic [15:0] pos_next;

   assign csr_ready = 1'b1;

   always_comb begin
      hole_cfg_in = hole_cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HOLE_ENABLE:     hole_cfg_in.enable = csr_wdata[0];
            CSR_CHECKSUM_OFFSET: hole_cfg_in.offset = csr_wdata[15:0];
            default:             hole_cfg_in = hole_cfg_ff;
         endcase
      end
   end

   // The result register can take a new word when empty or being drained.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // A non-final byte never needs the result register, so it always moves on.
   assign s1_advance = !s1_valid_ff || !s1_last_ff || out_free;
   assign s1_fire    = s1_valid_ff && s1_advance;
   assign req_stall  = !s1_advance;
   assign req_fire   = req_valid && !req_stall;

   assign s1_valid_in = s1_advance ? req_valid : s1_valid_ff;

   crc32h_update #(
      .PosLimit (PosLimit)
   ) u_update (
      .crc_cur    (crc_running_ff),
      .pos_cur    (byte_position_ff),
      .data_byte  (s1_data_ff),
      .first_byte (s1_first_ff),
      .hole_cfg   (hole_cfg_ff),
      .crc_next   (crc_next),
      .pos_next   (pos_next)
   );

   // After a last byte the CRC and position restart on their own.
   always_comb begin
      crc_running_in   = crc_running_ff;
      byte_position_in = byte_position_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            crc_running_in   = CRC_ALL_ONES;
            byte_position_in = 16'd0;
         end else begin
            crc_running_in   = crc_next;
            byte_position_in = pos_next;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_fire && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hole_cfg_ff      <= '0;
         s1_valid_ff      <= 1'b0;
         crc_running_ff   <= CRC_ALL_ONES;
         byte_position_ff <= 16'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         hole_cfg_ff      <= hole_cfg_in;
         s1_valid_ff      <= s1_valid_in;
         crc_running_ff   <= crc_running_in;
         byte_position_ff <= byte_position_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff  <= req_data_byte;
         s1_first_ff <= req_first_byte;
         s1_last_ff  <= req_last_byte;
      end
      if (s1_fire && s1_last_ff && out_free) begin
         rsp_crc_ff <= crc_next ^ CRC_ALL_ONES;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_crc_result = rsp_crc_ff;

   // Only a final byte waiting behind a held result may stall the input.
   `CRCH_ASSERT(a_stall_cause, clock, reset,
                !req_stall || (s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall))
   // A finished packet leaves the running state at its restart values.
   `CRCH_ASSERT_NEXT(a_restart, clock, reset, s1_fire && s1_last_ff,
                     crc_running_ff == CRC_ALL_ONES && byte_position_ff == 16'd0)
   // A final byte always lands in the result register.
   `CRCH_ASSERT_NEXT(a_result_loaded, clock, reset, s1_fire && s1_last_ff, rsp_valid_ff)
   // The byte position never passes its saturation point.
   `CRCH_ASSERT(a_pos_limit, clock, reset, byte_position_ff <= PosLimit)

endmodule

[tb/sv/tb_crc32_with_checksum_hole.sv]
// Self-checking testbench for the CRC-32 block with a zeroed checksum hole.
`timescale 1ns / 1ps

// Packets are fed as a stream of byte words. A word that carries the last mark
// yields one finished CRC-32. The hole setting, when enabled, zeroes the four
// bytes that start at the checksum offset. A bit-serial CRC predictor inside
// the bench works out each checksum when its last word is taken. A monitor
// then compares every result word, in order, against those predictions.
module tb_crc32_with_checksum_hole;

   import crc32h_pkg::*;

   // The byte position stops one short of the packet size limit, and never
   // goes past what a 16-bit counter can hold.
   localparam int unsigned POS_CEILING =
      (DefaultMaxPacketBytes - 1 > 65535) ? 65535 : DefaultMaxPacketBytes - 1;
   localparam int unsigned HOLE_SPAN = 4;
   // A last word passes the input and result registers to the result port.
   // The margin below also covers non-final bytes still being folded.
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   // About 1600 words are sent. The limit stays well above the length of the run
   // even if every one of them were a last word under the heaviest pacing.
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned WORDS_PER_SETTING = 180;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
   } pkt_word_type;

   typedef enum int {
      PKT_CLEAN,
      PKT_NO_FIRST,
      PKT_NO_LAST,
      PKT_NOISE
   } pkt_shape_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_first_byte = 1'b0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_crc_result;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_HOLE_ENABLE;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Words that are waiting to be sent, and the word now on the input port.
   pkt_word_type pending_words[$];
   pkt_word_type offered;
   // Checksums that are predicted but have not yet come out of the block.
   logic [31:0] crc_expect[$];
   logic [31:0] crc_want;

   // The bench keeps its own copy of the configuration and the packet state.
   logic        hole_on = 1'b0;
   int unsigned hole_start = 0;
   logic [31:0] run_crc = CRC_ALL_ONES;
   int unsigned run_pos = 0;

   // Flow-control knobs. The stimulus sets the pacing rates and hold request;
   // the driver and receiver read them, and the receiver runs the hold-off.
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   logic        hold_req = 1'b0;
   logic        hold_taken = 1'b0;
   int unsigned hold_left = 0;

   int unsigned words_sent = 0;
   int unsigned crcs_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned settings_used = 0;
   int unsigned cycle_count = 0;

   crc32_with_checksum_hole DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_crc_result (rsp_crc_result),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #10 clock = ~clock;

   // Reflected CRC-32 of one byte, taken one bit at a time, LSB first.
   function automatic logic [31:0] crc_shift_byte(input logic [31:0] crc,
                                                  input logic [7:0] b);
      logic [31:0] r;
      logic        fb;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ b[i];
         r = (r >> 1) ^ (fb ? CRC_POLY : 32'h0);
      end
      return r;
   endfunction

   // Folds one taken word into the predicted packet state. If the word is a
   // last word, the finished checksum goes into the queue of expectations.
   task automatic absorb_word(input pkt_word_type w);
      logic [7:0] fed;
      if (w.first) begin
         run_crc = CRC_ALL_ONES;
         run_pos = 0;
      end
      // The hole end does not wrap. A hole that starts near the top of the
      // position range simply reaches past it.
      if (hole_on && run_pos >= hole_start && run_pos < hole_start + HOLE_SPAN) begin
         fed = 8'h00;
      end else begin
         fed = w.data;
      end
      run_crc = crc_shift_byte(run_crc, fed);
      if (run_pos < POS_CEILING) begin
         run_pos++;
      end
      // A last word ends the packet. The state then restarts by itself, so
      // the next packet is still correct if its first mark is missing.
      if (w.last) begin
         crc_expect.push_back(~run_crc);
         run_crc = CRC_ALL_ONES;
         run_pos = 0;
      end
   endtask

   // Input driver. A word is taken at an edge where valid is high and stall
   // is low. A new word is offered only once the port is free, so the word
   // on the port stays fixed while the block stalls it.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_word(offered);
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = pending_words.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= offered.data;
               req_first_byte <= offered.first;
               req_last_byte <= offered.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver. Each result word is checked against the
   // oldest prediction. The stall for the next cycle is chosen at random,
   // or it comes from a long hold-off that this process counts down itself.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (crc_expect.size() == 0) begin
               $error("crc_result: no checksum expected, actual %08h", rsp_crc_result);
               mismatch_count++;
            end else begin
               crc_want = crc_expect.pop_front();
               if (rsp_crc_result !== crc_want) begin
                  $error("crc_result mismatch: expected %08h, actual %08h",
                         crc_want, rsp_crc_result);
                  mismatch_count++;
               end
               crcs_checked++;
            end
         end
         if (hold_req && !hold_taken) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Watchdog. If the run hangs, for example on a checksum that never
   // comes, it stops here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("crc32_with_checksum_hole test failed");
         $finish;
      end
   end

   task automatic push_word(input logic [7:0] data, input logic first, input logic last);
      pending_words.push_back('{data: data, first: first, last: last});
   endtask

   // Queues one packet of random bytes. The shape decides where the marks go:
   // a clean packet, a missing first or last mark, or marks at random.
   task automatic queue_packet(input int unsigned len, input pkt_shape_type shape);
      pkt_word_type w;
      for (int unsigned i = 0; i < len; i++) begin
         w.data = 8'($urandom);
         w.first = (i == 0) && (shape != PKT_NO_FIRST);
         w.last = (i == len - 1) && (shape != PKT_NO_LAST);
         if (shape == PKT_NOISE) begin
            w.first = 1'($urandom_range(1));
            w.last = ($urandom_range(3) == 0);
         end
         pending_words.push_back(w);
      end
   endtask

   // Queues random traffic. Most of it is clean packets, and short ones are
   // favored so that the hole lands inside them. The rest is broken packets
   // and random noise.
   task automatic queue_random_batch(input int unsigned n);
      int unsigned   queued;
      int unsigned   len;
      int unsigned   pick;
      pkt_shape_type shape;
      queued = 0;
      while (queued < n) begin
         pick = $urandom_range(99);
         len = (pick < 90) ? $urandom_range(24, 1) : $urandom_range(80, 25);
         pick = $urandom_range(99);
         if (pick < 80) begin
            shape = PKT_CLEAN;
         end else if (pick < 88) begin
            shape = PKT_NO_FIRST;
         end else if (pick < 94) begin
            shape = PKT_NO_LAST;
         end else begin
            shape = PKT_NOISE;
         end
         queue_packet(len, shape);
         queued += len;
      end
   endtask

   // Writes both registers with one valid pulse, one write per accepted
   // handshake. Call it only while the block is idle.
   task automatic write_config(input logic enable, input logic [15:0] offset);
      csr_valid <= 1'b1;
      csr_index <= CSR_HOLE_ENABLE;
      csr_wdata <= {15'd0, enable};
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_CHECKSUM_OFFSET;
      csr_wdata <= offset;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      hole_on = enable;
      hole_start = 32'(offset);
      settings_used++;
   endtask

   // Waits until every queued word has been taken and every checksum has
   // come out. It then leaves a short margin for bytes still in flight.
   task automatic wait_idle();
      while (pending_words.size() != 0 || req_valid || crc_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      write_config(1'b0, 16'd0);

      // Directed part, with the hole off. The packet starts with no first
      // mark, so its bytes build on the reset state. The bytes "123456789"
      // give the well-known check value.
      push_word(8'h31, 1'b0, 1'b0);
      push_word(8'h32, 1'b0, 1'b0);
      push_word(8'h33, 1'b0, 1'b0);
      push_word(8'h34, 1'b0, 1'b0);
      push_word(8'h35, 1'b0, 1'b0);
      push_word(8'h36, 1'b0, 1'b0);
      push_word(8'h37, 1'b0, 1'b0);
      push_word(8'h38, 1'b0, 1'b0);
      push_word(8'h39, 1'b0, 1'b1);
      // This packet follows a last word but carries no first mark.
      push_word(8'hAB, 1'b0, 1'b0);
      push_word(8'hCD, 1'b0, 1'b1);
      // Single-byte packets at both ends of the byte range.
      push_word(8'h00, 1'b1, 1'b1);
      push_word(8'hFF, 1'b1, 1'b1);
      // A first mark in mid-packet restarts the CRC.
      push_word(8'h11, 1'b1, 1'b0);
      push_word(8'h22, 1'b0, 1'b0);
      push_word(8'h33, 1'b1, 1'b0);
      push_word(8'h44, 1'b0, 1'b1);
      wait_idle();

      // The hole covers the first four bytes of the packet.
      write_config(1'b1, 16'd0);
      push_word(8'hDE, 1'b1, 1'b0);
      push_word(8'hAD, 1'b0, 1'b0);
      push_word(8'hBE, 1'b0, 1'b0);
      push_word(8'hEF, 1'b0, 1'b0);
      push_word(8'h01, 1'b0, 1'b0);
      push_word(8'h80, 1'b0, 1'b1);
      wait_idle();

      // The hole sits at the very top of the position range. Short packets
      // never reach it.
      write_config(1'b1, 16'hFFFF);
      push_word(8'hA5, 1'b1, 1'b1);
      queue_packet(12, PKT_CLEAN);
      wait_idle();
      // A hole that starts two bytes below the top reaches past the range,
      // and short packets stay clear of it as well.
      write_config(1'b1, 16'd65533);
      queue_packet(20, PKT_CLEAN);
      wait_idle();

      // Random traffic, run under four pacing mixes: no idling, a mostly idle
      // sender, a mostly stalling receiver, and some of both. Each mix runs
      // under two hole settings.
      for (int mode = 0; mode < 4; mode++) begin
         send_idle_pct <= (mode == 1) ? 78 : (mode == 3) ? 27 : 0;
         stall_pct <= (mode == 2) ? 78 : (mode == 3) ? 27 : 0;
         for (int s = 0; s < 2; s++) begin
            if (mode == 0 && s == 0) begin
               write_config(1'b0, 16'hFFFF);
            end else if ((mode * 2 + s) % 4 == 3) begin
               write_config(1'b1, 16'($urandom_range(65535)));
            end else begin
               write_config(1'b1, 16'($urandom_range(30)));
            end
            // The receiver holds off for a long stretch while the sender
            // keeps offering single-byte packets. The result register then
            // fills up, and the block has to stall its input.
            if (mode == 2 && s == 0) begin
               hold_req <= 1'b1;
               for (int p = 0; p < 40; p++) begin
                  queue_packet(1, PKT_CLEAN);
               end
            end
            queue_random_batch(WORDS_PER_SETTING);
            wait_idle();
         end
      end

      $display("Summary: %0d byte words fed and %0d checksums compared under %0d hole settings,",
               words_sent, crcs_checked, settings_used);
      $display("  four pacing mixes and a %0d-cycle result hold-off.", HOLD_OFF_CYCLES);
      if (mismatch_count == 0) begin
         $display("crc32_with_checksum_hole test passed");
      end else begin
         $display("crc32_with_checksum_hole test failed");
      end
      $finish;
   end

endmodule
